FILE: sv/hdu_pkg.sv
// Shared constants, types and helper functions of the haversine distance unit.
`timescale 1ns / 1ps

package hdu_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 24;
    localparam int CORDIC_ITERS = 30;
    localparam int Q30_W = 31;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD_3B6A;
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [12:0] TWICE_RADIUS_MILES = 13'd7922;
    localparam logic [29:0] DIST_MAX = 30'd815595520;

    typedef struct packed {
        logic [30:0] sin_mag;
        logic [30:0] cos_mag;
        logic        cos_neg;
    } trig_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] a;
        case (i)
            0: a = 32'h3243F6A8;
            1: a = 32'h1DAC6705;
            2: a = 32'h0FADBAFC;
            3: a = 32'h07F56EA6;
            4: a = 32'h03FEAB76;
            5: a = 32'h01FFD55B;
            6: a = 32'h00FFFAAA;
            7: a = 32'h007FFF55;
            8: a = 32'h003FFFEA;
            9: a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            24: a = 32'h0000003F;
            25: a = 32'h0000001F;
            26: a = 32'h0000000F;
            27: a = 32'h00000008;
            28: a = 32'h00000004;
            29: a = 32'h00000002;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // Clamps a signed CORDIC coordinate to [0, 1.0] in Q30.
    function automatic logic [30:0] clamp_q30(input logic signed [32:0] v);
        logic [30:0] c;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > $signed({2'b00, Q30_ONE}))
        begin
            c = Q30_ONE;
        end
        else
        begin
            c = v[30:0];
        end
        return c;
    endfunction

endpackage

FILE: sv/hdu_cordic_rot.sv
// Pipelined angle reduction and rotation CORDIC giving |sin|, |cos| and the cosine sign.
`timescale 1ns / 1ps

module hdu_cordic_rot
    import hdu_pkg::*;
#(
    parameter int FB   = 24,
    parameter int NRED = 2,
    parameter int IN_W = 34
)
(
    input  logic                   clk,
    input  logic signed [IN_W-1:0] angle,
    output trig_t                  result
);

    localparam longint FULL    = longint'(360) << FB;
    localparam longint HALF    = FULL / 2;
    localparam longint QUARTER = FULL / 4;
    localparam int     CW      = $clog2(FULL) + 1;
    localparam int     RW      = CW + NRED;
    localparam int     PW      = CW + 25;
    localparam int     XW      = 33;

    logic [RW-1:0] abs_reg;
    logic          sgn_reg;
    logic [RW-1:0] red_reg [NRED];
    logic          red_sgn_reg [NRED];
    logic [CW-1:0] m0_reg;
    logic [CW-1:0] fold_reg;
    logic          fold_neg_reg;
    logic [PW-1:0] prod_reg;
    logic          prod_neg_reg;
    logic signed [XW-1:0] x_reg [CORDIC_ITERS];
    logic signed [XW-1:0] y_reg [CORDIC_ITERS];
    logic signed [XW-1:0] z_reg [CORDIC_ITERS];
    logic          neg_reg [CORDIC_ITERS];
    trig_t         result_reg;

    logic [IN_W:0]  ang_ext;
    logic [IN_W:0]  ang_mag;
    logic [CW-1:0]  rem;
    logic [CW-1:0]  m0_next;
    logic [CW-1:0]  fold_next;
    logic           fold_neg_next;
    logic [PW-1:0]  z0_sum;
    logic signed [XW-1:0] z0;

    assign ang_ext = {angle[IN_W-1], angle};
    assign ang_mag = angle[IN_W-1] ? (~ang_ext + 1'b1) : ang_ext;

    always_ff @(posedge clk)
    begin
        abs_reg <= RW'(ang_mag);
        sgn_reg <= angle[IN_W-1];
    end

    // Restoring reduction of the magnitude modulo a full turn, one multiple per stage.
    for (genvar k = 0; k < NRED; k++)
    begin : g_red
        localparam logic [RW-1:0] SUB = RW'(FULL) << (NRED - 1 - k);
        logic [RW-1:0] cur;
        logic          cur_sgn;
        if (k == 0)
        begin : g_first
            assign cur     = abs_reg;
            assign cur_sgn = sgn_reg;
        end
        else
        begin : g_next
            assign cur     = red_reg[k-1];
            assign cur_sgn = red_sgn_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            red_reg[k]     <= (cur >= SUB) ? (cur - SUB) : cur;
            red_sgn_reg[k] <= cur_sgn;
        end
    end

    assign rem = red_reg[NRED-1][CW-1:0];

    always_comb
    begin
        if (red_sgn_reg[NRED-1] && (rem != '0))
        begin
            m0_next = CW'(FULL) - rem;
        end
        else
        begin
            m0_next = rem;
        end
    end

    always_comb
    begin
        fold_next     = m0_reg;
        fold_neg_next = 1'b0;
        if (fold_next > CW'(HALF))
        begin
            fold_next = CW'(FULL) - fold_next;
        end
        if (fold_next > CW'(QUARTER))
        begin
            fold_next     = CW'(HALF) - fold_next;
            fold_neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg       <= m0_next;
        fold_reg     <= fold_next;
        fold_neg_reg <= fold_neg_next;
        prod_reg     <= PW'(fold_reg) * PW'(DEG2RAD_Q30);
        prod_neg_reg <= fold_neg_reg;
    end

    assign z0_sum = prod_reg + (PW'(1) << (FB - 1));
    assign z0     = $signed(XW'(z0_sum >> FB));

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        localparam logic signed [XW-1:0] ATAN = $signed({1'b0, atan_q30(i)});
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [XW-1:0] zi;
        logic                 ni;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        if (i == 0)
        begin : g_init
            assign xi = $signed({1'b0, CORDIC_GAIN_Q30});
            assign yi = '0;
            assign zi = z0;
            assign ni = prod_neg_reg;
        end
        else
        begin : g_chain
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = neg_reg[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        always_ff @(posedge clk)
        begin
            if (zi >= 0)
            begin
                x_reg[i] <= xi - dx;
                y_reg[i] <= yi + dy;
                z_reg[i] <= zi - ATAN;
            end
            else
            begin
                x_reg[i] <= xi + dx;
                y_reg[i] <= yi - dy;
                z_reg[i] <= zi + ATAN;
            end
            neg_reg[i] <= ni;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.sin_mag <= clamp_q30(y_reg[CORDIC_ITERS-1]);
        result_reg.cos_mag <= clamp_q30(x_reg[CORDIC_ITERS-1]);
        result_reg.cos_neg <= neg_reg[CORDIC_ITERS-1];
    end

    assign result = result_reg;

endmodule

FILE: sv/hdu_isqrt.sv
// Pipelined exact integer square root, one result bit per stage.
`timescale 1ns / 1ps

module hdu_isqrt
    import hdu_pkg::*;
#(
    parameter int IN_W = 61
)
(
    input  logic                      clk,
    input  logic [IN_W-1:0]           radicand,
    output logic [(IN_W+1)/2-1:0]     root
);

    localparam int OUT_W = (IN_W + 1) / 2;
    localparam int SW    = IN_W + 2;

    logic [IN_W-1:0] n_reg [OUT_W];
    logic [IN_W:0]   r_reg [OUT_W];

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_bit
        localparam logic [SW-1:0] B = SW'(1) << (2 * (OUT_W - 1 - s));
        logic [IN_W-1:0] ni;
        logic [IN_W:0]   ri;
        logic [SW-1:0]   trial;
        if (s == 0)
        begin : g_first
            assign ni = radicand;
            assign ri = '0;
        end
        else
        begin : g_next
            assign ni = n_reg[s-1];
            assign ri = r_reg[s-1];
        end
        assign trial = SW'(ri) + B;
        always_ff @(posedge clk)
        begin
            if (SW'(ni) >= trial)
            begin
                n_reg[s] <= IN_W'(SW'(ni) - trial);
                r_reg[s] <= (IN_W+1)'((SW'(ri) >> 1) + B);
            end
            else
            begin
                n_reg[s] <= ni;
                r_reg[s] <= ri >> 1;
            end
        end
    end

    assign root = r_reg[OUT_W-1][OUT_W-1:0];

endmodule

FILE: sv/haversine_distance_unit.sv
// Top level of the pipelined haversine great-circle distance unit.
//
//   channel   direction  ports                                          handshake
//   command   in         lat_a_deg lon_a_deg lat_b_deg lon_b_deg         start, busy
//   result    out        distance_miles                                  done strobe
//
// One word is taken in every cycle; busy never rises. Each command passes through
// the four CORDIC trig pipelines, two 31-stage square root pipelines and the
// 30-stage arcsine CORDIC on its way to the result.
// The done strobe is high for one cycle.
// Reset clears only the valid bits; the data path has no reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module haversine_distance_unit
    import hdu_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] lat_a_deg,
    input  logic signed [32:0] lon_a_deg,
    input  logic signed [31:0] lat_b_deg,
    input  logic signed [32:0] lon_b_deg,
    output logic               done,
    output logic [29:0]        distance_miles
);

    localparam longint FULL_MIN  = longint'(360) << ANGLE_FRAC_BITS;
    localparam int     C_MIN     = $clog2(FULL_MIN);
    localparam int     NRED      = (36 - C_MIN > 1) ? (36 - C_MIN) : 1;
    localparam int     ROT_LAT   = NRED + 35;
    localparam int     ISQ_LAT   = 31;
    localparam int     R_STAGE   = ROT_LAT + 3 + ISQ_LAT;
    localparam int     C_STAGE   = R_STAGE + 1 + ISQ_LAT;
    localparam int     TOTAL_LAT = C_STAGE + CORDIC_ITERS + 2;
    localparam int     VW        = 34;
    localparam int     ZW        = 33;

    logic signed [33:0] dlat;
    logic signed [33:0] dlon;
    trig_t              t_dlat;
    trig_t              t_dlon;
    trig_t              t_lat_a;
    trig_t              t_lat_b;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 accept;

    logic [30:0] p_reg;
    logic [30:0] sl2_reg;
    logic [30:0] h0_reg;
    logic        sub_reg;
    logic [30:0] q_reg;
    logic [30:0] h0_b_reg;
    logic        sub_b_reg;
    logic [30:0] h_reg;
    logic [30:0] r;
    logic [30:0] r_sq_reg;
    logic [60:0] rest_reg;
    logic [30:0] r_dly_reg [ISQ_LAT];
    logic [30:0] c;
    logic signed [VW-1:0] vx_reg [CORDIC_ITERS];
    logic signed [VW-1:0] vy_reg [CORDIC_ITERS];
    logic signed [ZW-1:0] vz_reg [CORDIC_ITERS];
    logic [30:0] ang_reg;
    logic [29:0] dist_reg;

    logic [61:0] p_full;
    logic [61:0] sl2_full;
    logic [61:0] h0_full;
    logic [61:0] q_full;
    logic signed [32:0] h_sum;
    logic [30:0] h_next;
    logic [61:0] rr_full;
    logic [61:0] rest_full;
    logic signed [ZW-1:0] vz_last;
    logic [30:0] ang_next;
    logic [43:0] dist_full;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign dlat = 34'(lat_b_deg) - 34'(lat_a_deg);
    assign dlon = 34'(lon_b_deg) - 34'(lon_a_deg);

    // Half-differences are the raw differences read with one extra fraction bit.
    hdu_cordic_rot #(.FB(ANGLE_FRAC_BITS + 1), .NRED(NRED), .IN_W(34)) u_rot_dlat
    (
        .clk    (clk),
        .angle  (dlat),
        .result (t_dlat)
    );

    hdu_cordic_rot #(.FB(ANGLE_FRAC_BITS + 1), .NRED(NRED), .IN_W(34)) u_rot_dlon
    (
        .clk    (clk),
        .angle  (dlon),
        .result (t_dlon)
    );

    hdu_cordic_rot #(.FB(ANGLE_FRAC_BITS), .NRED(NRED), .IN_W(34)) u_rot_lat_a
    (
        .clk    (clk),
        .angle  (34'(lat_a_deg)),
        .result (t_lat_a)
    );

    hdu_cordic_rot #(.FB(ANGLE_FRAC_BITS), .NRED(NRED), .IN_W(34)) u_rot_lat_b
    (
        .clk    (clk),
        .angle  (34'(lat_b_deg)),
        .result (t_lat_b)
    );

    assign p_full   = 62'(t_lat_a.cos_mag) * 62'(t_lat_b.cos_mag);
    assign sl2_full = 62'(t_dlon.sin_mag) * 62'(t_dlon.sin_mag);
    assign h0_full  = 62'(t_dlat.sin_mag) * 62'(t_dlat.sin_mag);
    assign q_full   = 62'(p_reg) * 62'(sl2_reg);

    always_ff @(posedge clk)
    begin
        p_reg     <= p_full[60:30];
        sl2_reg   <= sl2_full[60:30];
        h0_reg    <= h0_full[60:30];
        sub_reg   <= t_lat_a.cos_neg ^ t_lat_b.cos_neg;
        q_reg     <= q_full[60:30];
        h0_b_reg  <= h0_reg;
        sub_b_reg <= sub_reg;
        h_reg     <= h_next;
    end

    always_comb
    begin
        if (sub_b_reg)
        begin
            h_sum = $signed({2'b00, h0_b_reg}) - $signed({2'b00, q_reg});
        end
        else
        begin
            h_sum = $signed({2'b00, h0_b_reg}) + $signed({2'b00, q_reg});
        end
        if (h_sum < 0)
        begin
            h_next = '0;
        end
        else if (h_sum > $signed({2'b00, Q30_ONE}))
        begin
            h_next = Q30_ONE;
        end
        else
        begin
            h_next = h_sum[30:0];
        end
    end

    hdu_isqrt #(.IN_W(61)) u_isqrt_r
    (
        .clk      (clk),
        .radicand ({h_reg, 30'b0}),
        .root     (r)
    );

    assign rr_full   = 62'(r) * 62'(r);
    assign rest_full = (62'(1) << 60) - rr_full;

    always_ff @(posedge clk)
    begin
        r_sq_reg <= r;
        rest_reg <= rest_full[60:0];
    end

    hdu_isqrt #(.IN_W(61)) u_isqrt_c
    (
        .clk      (clk),
        .radicand (rest_reg),
        .root     (c)
    );

    // Keeps r lined up with the second square root.
    for (genvar d = 0; d < ISQ_LAT; d++)
    begin : g_rdly
        always_ff @(posedge clk)
        begin
            if (d == 0)
            begin
                r_dly_reg[d] <= r_sq_reg;
            end
            else
            begin
                r_dly_reg[d] <= r_dly_reg[(d == 0) ? 0 : d-1];
            end
        end
    end

    // Arcsine as atan2(r, c) by vectoring CORDIC.
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_vec
        localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, atan_q30(i)});
        logic signed [VW-1:0] xi;
        logic signed [VW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        if (i == 0)
        begin : g_init
            assign xi = $signed(VW'(c));
            assign yi = $signed(VW'(r_dly_reg[ISQ_LAT-1]));
            assign zi = '0;
        end
        else
        begin : g_chain
            assign xi = vx_reg[i-1];
            assign yi = vy_reg[i-1];
            assign zi = vz_reg[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        always_ff @(posedge clk)
        begin
            if (yi >= 0)
            begin
                vx_reg[i] <= xi + dx;
                vy_reg[i] <= yi - dy;
                vz_reg[i] <= zi + ATAN;
            end
            else
            begin
                vx_reg[i] <= xi - dx;
                vy_reg[i] <= yi + dy;
                vz_reg[i] <= zi - ATAN;
            end
        end
    end

    assign vz_last = vz_reg[CORDIC_ITERS-1];

    always_comb
    begin
        if (vz_last < 0)
        begin
            ang_next = '0;
        end
        else if (vz_last > $signed({2'b00, HALF_PI_Q30}))
        begin
            ang_next = HALF_PI_Q30;
        end
        else
        begin
            ang_next = vz_last[30:0];
        end
    end

    assign dist_full = 44'(ang_reg) * 44'(TWICE_RADIUS_MILES) + (44'(1) << 13);

    always_ff @(posedge clk)
    begin
        ang_reg  <= ang_next;
        dist_reg <= dist_full[43:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], accept};
        end
    end

    assign done           = vld_reg[TOTAL_LAT-1];
    assign distance_miles = dist_reg;

`ifndef NO_ASSERTIONS
    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LAT))
        else $error("result strobe without a matching command word");

    a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance_miles <= DIST_MAX))
        else $error("distance beyond half the circumference");

    a_root_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[R_STAGE-1] |-> (r <= Q30_ONE))
        else $error("square root of the haversine term exceeds one");

    a_cos_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[C_STAGE-1] |-> (c <= Q30_ONE))
        else $error("cosine term of the arcsine exceeds one");
`endif

endmodule
